[sv/qps_pkg.sv]
// Shared widths, register indexes, reset values and pipeline control types
// for the quadrature position servo. No dependencies.
package qps_pkg;

   localparam int POS_W      = 32;
   localparam int GAIN_W     = 32;
   localparam int TOL_W      = 16;
   localparam int DUTY_W     = 16;
   localparam int ERR_W      = POS_W + 1;
   localparam int MAG_LO_W   = 16;
   localparam int MAG_HI_W   = ERR_W - MAG_LO_W;
   localparam int PLO_W      = MAG_LO_W + GAIN_W;
   localparam int PHI_W      = MAG_HI_W + GAIN_W;
   localparam int SUM_W      = PHI_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_TOP   = 2'd3;

   localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 16'd10;
   localparam logic [DUTY_W-1:0] PWM_TOP_RESET   = 16'd400;

   // Load strobes for the two register stages inside one module.
   typedef struct packed {
      logic load_first;
      logic load_second;
   } qps_en_type;

endpackage

[sv/qps_counter.sv]
// Quadrature decoder and wrapping tick counter (pipeline stage 1).
// Depends on qps_pkg.
module qps_counter
   import qps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             pin_a,
   input  logic             pin_b,
   input  logic             clear_count,
   output logic [POS_W-1:0] count
);

   logic [POS_W-1:0] tick_count_ff, tick_count_in;
   logic             last_a_ff, last_b_ff;
   logic signed [2:0] a_step, b_step, delta;

   // A rule judges against the old B; B rule against the new A.
   always_comb begin
      a_step = 3'sd0;
      b_step = 3'sd0;
      if (pin_a != last_a_ff) begin
         a_step = (pin_a == last_b_ff) ? -3'sd1 : 3'sd1;
      end
      if (pin_b != last_b_ff) begin
         b_step = (pin_a == pin_b) ? 3'sd1 : -3'sd1;
      end
      delta = a_step + b_step;
      if (clear_count) begin
         tick_count_in = '0;
      end else begin
         tick_count_in = tick_count_ff + {{(POS_W-3){delta[2]}}, delta};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         last_a_ff     <= 1'b0;
         last_b_ff     <= 1'b0;
      end else if (accept) begin
         tick_count_ff <= tick_count_in;
         last_a_ff     <= pin_a;
         last_b_ff     <= pin_b;
      end
   end

   assign count = tick_count_ff;

endmodule

[sv/qps_error.sv]
// Position error stages: exact 33-bit difference, then magnitude, sign and
// tolerance compare (pipeline stages 2 and 3). Depends on qps_pkg.
module qps_error
   import qps_pkg::*;
(
   input  logic             clock,
   input  qps_en_type       en,
   input  logic [POS_W-1:0] target,
   input  logic [TOL_W-1:0] tolerance,
   input  logic [POS_W-1:0] position,
   output logic [ERR_W-1:0] mag,
   output logic             neg,
   output logic             reached,
   output logic [POS_W-1:0] position_out
);

   logic [ERR_W-1:0] err_ff, err_in;
   logic [POS_W-1:0] pos2_ff, pos3_ff;
   logic [ERR_W-1:0] mag_ff, mag_in;
   logic             neg_ff, reached_ff, reached_in;

   assign err_in = {target[POS_W-1], target} - {position[POS_W-1], position};

   // Magnitude fits unsigned in 33 bits; it is at most 2^32 - 1.
   assign mag_in     = err_ff[ERR_W-1] ? (~err_ff + 1'b1) : err_ff;
   assign reached_in = mag_in < {{(ERR_W-TOL_W){1'b0}}, tolerance};

   always_ff @(posedge clock) begin
      if (en.load_first) begin
         err_ff  <= err_in;
         pos2_ff <= position;
      end
      if (en.load_second) begin
         mag_ff     <= mag_in;
         neg_ff     <= err_ff[ERR_W-1];
         reached_ff <= reached_in;
         pos3_ff    <= pos2_ff;
      end
   end

   assign mag          = mag_ff;
   assign neg          = neg_ff;
   assign reached      = reached_ff;
   assign position_out = pos3_ff;

endmodule

[sv/qps_drive.sv]
// Drive stages: split gain product into two partial products, then sum,
// truncate and saturate into the result register (stages 4 and 5).
// Depends on qps_pkg.
module qps_drive
   import qps_pkg::*;
(
   input  logic              clock,
   input  qps_en_type        en,
   input  logic [GAIN_W-1:0] gain,
   input  logic [DUTY_W-1:0] pwm_top,
   input  logic [ERR_W-1:0]  mag,
   input  logic              neg,
   input  logic              reached,
   input  logic [POS_W-1:0]  position,
   output logic [POS_W-1:0]  rsp_position,
   output logic [DUTY_W-1:0] rsp_duty,
   output logic              rsp_reverse,
   output logic              rsp_at_target
);

   logic [PLO_W-1:0]  p_lo_ff, p_lo_in;
   logic [PHI_W-1:0]  p_hi_ff, p_hi_in;
   logic              neg4_ff, reached4_ff;
   logic [POS_W-1:0]  pos4_ff, pos5_ff;
   logic [SUM_W-1:0]  full;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              reverse_ff, at_target_ff;

   // mag = hi*2^16 + lo, so (mag*gain)>>16 = hi*gain + (lo*gain)>>16 exactly.
   assign p_lo_in = PLO_W'(mag[MAG_LO_W-1:0]) * PLO_W'(gain);
   assign p_hi_in = PHI_W'(mag[ERR_W-1:MAG_LO_W]) * PHI_W'(gain);
   assign full    = SUM_W'(p_hi_ff) + SUM_W'(p_lo_ff[PLO_W-1:MAG_LO_W]);

   always_comb begin
      if (reached4_ff) begin
         duty_in = '0;
      end else if (full > SUM_W'(pwm_top)) begin
         duty_in = pwm_top;
      end else begin
         duty_in = full[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_first) begin
         p_lo_ff     <= p_lo_in;
         p_hi_ff     <= p_hi_in;
         neg4_ff     <= neg;
         reached4_ff <= reached;
         pos4_ff     <= position;
      end
      if (en.load_second) begin
         duty_ff      <= duty_in;
         reverse_ff   <= neg4_ff & ~reached4_ff;
         at_target_ff <= reached4_ff;
         pos5_ff      <= pos4_ff;
      end
   end

   assign rsp_position  = pos5_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_reverse   = reverse_ff;
   assign rsp_at_target = at_target_ff;

endmodule

[sv/quadrature_position_servo_top.sv]
// Top level of the quadrature position servo: configuration registers,
// pipeline valid/ready control. Depends on qps_pkg, qps_counter,
// qps_error and qps_drive.
//
// One item is one clock sample of encoder pins A and B plus a clear flag;
// each item yields exactly one result with the updated tick count, the
// PWM duty, the drive direction and an at-target flag. The block takes one
// item per cycle while rsp_ready does not hold the pipeline back; the result
// comes out on rsp_valid from the output register of the last stage.
// It passes through the tick counter (stage 1), the 33-bit error (2),
// magnitude and tolerance compare (3), two partial products of magnitude
// times gain (4), and the sum, truncation and saturation into the output
// register (5). The only loop carried from item to item is the tick count
// update in stage 1, which sets the rate at one item per clock.
// Every stage moves forward whenever the stage after it is empty or moving,
// so bubbles close up and req_ready stays high while a result waits, until
// all five stages are full. Configuration registers are written through
// csr_we, csr_index and csr_wdata with no wait; write them only while the
// pipeline is empty.
module quadrature_position_servo_top
   import qps_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_pin_a,
   input  logic                    req_pin_b,
   input  logic                    req_clear_count,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_position,
   output logic [DUTY_W-1:0]       rsp_duty,
   output logic                    rsp_reverse,
   output logic                    rsp_at_target,
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic [POS_W-1:0]  target_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [TOL_W-1:0]  tolerance_ff;
   logic [DUTY_W-1:0] pwm_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         gain_ff      <= '0;
         tolerance_ff <= TOLERANCE_RESET;
         pwm_top_ff   <= PWM_TOP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET:    target_ff    <= csr_wdata[POS_W-1:0];
            CSR_GAIN:      gain_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_TOLERANCE: tolerance_ff <= csr_wdata[TOL_W-1:0];
            CSR_PWM_TOP:   pwm_top_ff   <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits; stage 5 is the result register.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;
   logic accept;

   // A stage advances when it is empty or the next stage advances.
   assign adv5   = ~v5_ff | rsp_ready;
   assign adv4   = ~v4_ff | adv5;
   assign adv3   = ~v3_ff | adv4;
   assign adv2   = ~v2_ff | adv3;
   assign adv1   = ~v1_ff | adv2;
   assign accept = req_valid & adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   assign req_ready = adv1;
   assign rsp_valid = v5_ff;

   // Datapath.
   logic [POS_W-1:0]  count;
   logic [ERR_W-1:0]  mag;
   logic              neg, reached;
   logic [POS_W-1:0]  pos3;
   logic [POS_W-1:0]  pos_out;
   qps_en_type        err_en, drv_en;

   assign err_en.load_first  = adv2;
   assign err_en.load_second = adv3;
   assign drv_en.load_first  = adv4;
   assign drv_en.load_second = adv5;

   qps_counter u_counter (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pin_a       (req_pin_a),
      .pin_b       (req_pin_b),
      .clear_count (req_clear_count),
      .count       (count)
   );

   qps_error u_error (
      .clock        (clock),
      .en           (err_en),
      .target       (target_ff),
      .tolerance    (tolerance_ff),
      .position     (count),
      .mag          (mag),
      .neg          (neg),
      .reached      (reached),
      .position_out (pos3)
   );

   qps_drive u_drive (
      .clock         (clock),
      .en            (drv_en),
      .gain          (gain_ff),
      .pwm_top       (pwm_top_ff),
      .mag           (mag),
      .neg           (neg),
      .reached       (reached),
      .position      (pos3),
      .rsp_position  (pos_out),
      .rsp_duty      (rsp_duty),
      .rsp_reverse   (rsp_reverse),
      .rsp_at_target (rsp_at_target)
   );

   assign rsp_position = $signed(pos_out);

endmodule

[sv/qps_checker.sv]
// Port-level checks for quadrature_position_servo_top, bound to the top.
// Depends on qps_pkg.
module qps_checker
   import qps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  rsp_position,
   input logic [DUTY_W-1:0] rsp_duty,
   input logic              rsp_reverse,
   input logic              rsp_at_target
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_duty) && $stable(rsp_reverse) && $stable(rsp_at_target))
      else $error("stalled result changed");

   // At target means zero drive and no reverse.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_target |-> rsp_duty == '0 && !rsp_reverse)
      else $error("drive active at target");

   // An empty output register never blocks input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // No result right after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind quadrature_position_servo_top qps_checker u_qps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_position  (rsp_position),
   .rsp_duty      (rsp_duty),
   .rsp_reverse   (rsp_reverse),
   .rsp_at_target (rsp_at_target)
);

[tb/tb_quadrature_position_servo_top.sv]
// Self-checking testbench for quadrature_position_servo_top: a directed table
// of encoder samples and register writes, then random quadrature traffic.
// Depends on qps_pkg and the servo RTL only.
module tb_quadrature_position_servo_top
   import qps_pkg::*;
();

   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 10;     // five pipe stages, plus margin
   localparam int LONG_STALL   = 60;     // receiver hold-off, longer than the pipe depth
   localparam int PHASE_ITEMS  = 100;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [DUTY_W-1:0] duty;
      logic              reverse;
      logic              at_target;
   } servo_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic                  pin_a;
      logic                  pin_b;
      logic                  clear;
      logic                  typed;    // expectation written into the row
      servo_result_type      want;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_pin_a = 1'b0;
   logic                  req_pin_b = 1'b0;
   logic                  req_clear_count = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_position;
   logic [DUTY_W-1:0]     rsp_duty;
   logic                  rsp_reverse;
   logic                  rsp_at_target;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TARGET;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   quadrature_position_servo_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pin_a       (req_pin_a),
      .req_pin_b       (req_pin_b),
      .req_clear_count (req_clear_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_duty        (rsp_duty),
      .rsp_reverse     (rsp_reverse),
      .rsp_at_target   (rsp_at_target),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Servo predictor: own copy of the registers and the encoder state.
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]  target_reg = '0;
   logic [GAIN_W-1:0] gain_reg   = '0;
   logic [TOL_W-1:0]  tol_reg    = TOLERANCE_RESET;
   logic [DUTY_W-1:0] top_reg    = PWM_TOP_RESET;
   logic [POS_W-1:0]  tick_model = '0;
   logic              enc_a      = 1'b0;
   logic              enc_b      = 1'b0;

   servo_result_type pending_drive[$];   // expected results, oldest first
   stim_row_type     directed_rows[$];
   int               fault_count = 0;

   // Advance the encoder by one sample and form the drive for it.
   function automatic servo_result_type advance_servo(logic a, logic b, logic clr);
      logic [ERR_W-1:0] err;
      logic [ERR_W-1:0] mag;
      logic [63:0]      product;
      servo_result_type r;
      // A edge judged against the old B, then B edge against the new A
      if (a != enc_a) begin
         enc_a = a;
         if (enc_a == enc_b) tick_model = tick_model - 1'b1;
         else tick_model = tick_model + 1'b1;
      end
      if (b != enc_b) begin
         enc_b = b;
         if (enc_a == enc_b) tick_model = tick_model + 1'b1;
         else tick_model = tick_model - 1'b1;
      end
      if (clr) tick_model = '0;

      // 33-bit difference of sign-extended values never wraps
      err = {target_reg[POS_W-1], target_reg} - {tick_model[POS_W-1], tick_model};
      mag = err[ERR_W-1] ? (~err + 1'b1) : err;
      r.position = tick_model;
      if (mag < {{(ERR_W-TOL_W){1'b0}}, tol_reg}) begin
         r.duty      = '0;
         r.reverse   = 1'b0;
         r.at_target = 1'b1;
      end else begin
         product     = 64'(mag) * 64'(gain_reg);
         r.duty      = (product[63:16] > {32'b0, top_reg}) ? top_reg : product[31:16];
         r.reverse   = err[ERR_W-1];
         r.at_target = 1'b0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table builders.
   // ---------------------------------------------------------------------
   function automatic void row_item(logic a, logic b, logic clr);
      stim_row_type row;
      row = '{ROW_ITEM, a, b, clr, 1'b0, '0, CSR_TARGET, '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void row_typed(logic a, logic b, logic clr, logic [POS_W-1:0] pos,
                                     logic [DUTY_W-1:0] duty, logic rev, logic at);
      stim_row_type row;
      row = '{ROW_ITEM, a, b, clr, 1'b1, '{pos, duty, rev, at}, CSR_TARGET, '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void row_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{ROW_CSR, 1'b0, 1'b0, 1'b0, 1'b0, '0, idx, data};
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // Sender: random gaps, then hold the item until it is taken.
   // ---------------------------------------------------------------------
   int send_gap_pct = 0;

   task automatic send_item(input logic a, input logic b, input logic clr,
                            input logic use_want, input servo_result_type want);
      servo_result_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pin_a       <= a;
      req_pin_b       <= b;
      req_clear_count <= clr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // taken at this edge: step the predictor even when the row carries its own answer
      predicted = advance_servo(a, b, clr);
      pending_drive.push_back(use_want ? want : predicted);
   endtask

   // Drop valid and wait until every expected result is back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
   endtask

   // One register write; the extra edge keeps csr_we to one assignment per step.
   task automatic write_servo_reg(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TARGET:    target_reg = data;
         CSR_GAIN:      gain_reg   = data;
         CSR_TOLERANCE: tol_reg    = data[TOL_W-1:0];
         CSR_PWM_TOP:   top_reg    = data[DUTY_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off on request.
   // ---------------------------------------------------------------------
   int recv_gap_pct = 0;
   int stall_asks   = 0;   // bumped by the stimulus
   int stall_taken  = 0;   // receiver side only
   int stall_left   = 0;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_taken != stall_asks) begin
         // hold off long enough for the pipe to fill and req_ready to drop
         stall_taken <= stall_asks;
         stall_left  <= LONG_STALL;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker.
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      servo_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive.size() == 0) begin
            fault_count++;
            $display("%0t: result with none expected, actual position 0x%0h duty 0x%0h",
                     $time, rsp_position, rsp_duty);
         end else begin
            want = pending_drive.pop_front();
            check_field("position",  want.position,  rsp_position);
            check_field("duty",      want.duty,      rsp_duty);
            check_field("reverse",   want.reverse,   rsp_reverse);
            check_field("at_target", want.at_target, rsp_at_target);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------
   int send_gaps[3] = '{19, 60, 0};
   int recv_gaps[3] = '{60, 19, 0};

   initial begin : stimulus
      logic             na, nb, nc;
      logic             fwd;
      int               roll;
      servo_result_type none;
      none = '0;
      fwd  = 1'b1;

      // Directed table: counting in both directions, wrap below zero, both pins
      // at once, clear with edges, then the drive at its extremes.
      row_typed(1'b0, 1'b0, 1'b0, 32'd0, 16'd0, 1'b0, 1'b1);   // reset state
      row_item(1'b1, 1'b0, 1'b0);
      row_item(1'b1, 1'b1, 1'b0);
      row_item(1'b0, 1'b1, 1'b0);
      row_item(1'b0, 1'b0, 1'b0);
      row_item(1'b0, 1'b1, 1'b0);
      row_item(1'b1, 1'b1, 1'b0);
      row_item(1'b1, 1'b0, 1'b0);
      row_item(1'b0, 1'b0, 1'b0);
      row_item(1'b0, 1'b1, 1'b0);                               // count goes below zero
      row_item(1'b1, 1'b0, 1'b0);                               // both pins change
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'd0, 1'b0, 1'b1);    // clear wins over edges
      row_csr(CSR_GAIN, 32'hFFFF_FFFF);
      row_csr(CSR_PWM_TOP, 32'h0000_FFFF);
      row_csr(CSR_TARGET, 32'h7FFF_FFFF);
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'hFFFF, 1'b0, 1'b0);
      row_csr(CSR_TARGET, 32'h8000_0000);
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'hFFFF, 1'b1, 1'b0);
      row_item(1'b1, 1'b1, 1'b0);
      row_csr(CSR_TARGET, 32'd0);
      row_csr(CSR_TOLERANCE, 32'd0);
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'd0, 1'b0, 1'b0);    // zero tolerance never reached
      row_csr(CSR_TOLERANCE, 32'h0000_FFFF);
      row_csr(CSR_TARGET, 32'h7FFF_FFFF);
      row_item(1'b0, 1'b1, 1'b1);
      row_csr(CSR_TOLERANCE, 32'd10);
      row_csr(CSR_PWM_TOP, 32'd0);
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'd0, 1'b0, 1'b0);    // zero top pins duty at 0
      row_csr(CSR_GAIN, 32'h0001_0000);
      row_csr(CSR_PWM_TOP, 32'd400);
      row_csr(CSR_TARGET, 32'd300);
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'd300, 1'b0, 1'b0);
      row_csr(CSR_TARGET, 32'hFFFF_FED4);                       // -300
      row_typed(1'b0, 1'b1, 1'b1, 32'd0, 16'd300, 1'b1, 1'b0);
      row_item(1'b0, 1'b0, 1'b0);
      row_csr(CSR_GAIN, 32'h0000_8000);                         // half gain, fraction dropped
      row_item(1'b1, 1'b0, 1'b0);
      row_csr(CSR_TARGET, 32'd300);
      row_csr(CSR_TOLERANCE, 32'd300);
      row_item(1'b0, 1'b1, 1'b1);                               // error equals tolerance
      row_item(1'b0, 1'b0, 1'b0);                               // one tick inside it

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_servo_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_item(directed_rows[i].pin_a, directed_rows[i].pin_b, directed_rows[i].clear,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random part: three back-pressure modes, four register settings each.
      for (int mode = 0; mode < 3; mode++) begin
         send_gap_pct = send_gaps[mode];
         recv_gap_pct <= recv_gaps[mode];
         for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            if ($urandom_range(4) == 0) begin
               // wide setting: anything the registers hold
               write_servo_reg(CSR_TARGET, $urandom);
               write_servo_reg(CSR_GAIN, $urandom);
               write_servo_reg(CSR_TOLERANCE, $urandom_range(65535));
               write_servo_reg(CSR_PWM_TOP, $urandom_range(65535));
            end else begin
               // target near the count so the drive passes through its linear
               // range and the at-target window
               write_servo_reg(CSR_TARGET, tick_model + 32'($urandom_range(600)) - 32'd300);
               write_servo_reg(CSR_GAIN, $urandom_range(32'h0004_0000));
               write_servo_reg(CSR_TOLERANCE, $urandom_range(40));
               write_servo_reg(CSR_PWM_TOP, $urandom_range(1000, 1));
            end
            if (mode == 2 && ph == 0) stall_asks <= stall_asks + 1;

            repeat (PHASE_ITEMS) begin
               roll = $urandom_range(99);
               if (roll < 3) begin
                  na = 1'($urandom_range(1));
                  nb = 1'($urandom_range(1));
                  nc = 1'b1;
               end else if (roll < 15) begin
                  // noise: random pins, so no change, a single step or both pins at once
                  na = 1'($urandom_range(1));
                  nb = 1'($urandom_range(1));
                  nc = 1'b0;
               end else begin
                  // one clean quadrature step; reverse now and then
                  if ($urandom_range(99) < 8) fwd = !fwd;
                  na = enc_a;
                  nb = enc_b;
                  nc = 1'b0;
                  if ((enc_a == enc_b) == fwd) na = !enc_a;
                  else nb = !enc_b;
               end
               send_item(na, nb, nc, 1'b0, none);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/qps_pkg.sv
sv/qps_counter.sv
sv/qps_error.sv
sv/qps_drive.sv
sv/quadrature_position_servo_top.sv
sv/qps_checker.sv
tb/tb_quadrature_position_servo_top.sv
